// File: src/tss_pkg.sv
package tss_pkg;

  localparam int MAX_CANDIDATES = 8;
  localparam int VAL_W          = 48;
  localparam int GOAL_W         = 50;
  localparam int IDX_OUT_W      = 3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH_I,
    S_LOAD_I,
    S_FETCH_J,
    S_LOAD_J,
    S_FETCH_K,
    S_CHECK,
    S_FINISH
  } state_t;

endpackage

// File: src/three_sum_search_unit.sv
// an item not marked last is taken while idle and gives no result
// an item marked last starts a search (with fewer than three candidates it goes straight to the close);
// each triple takes a read of the third candidate and a check, each change of the second index a read
// and load of it, each change of the first likewise, and a closing state ends the run; the store has a single read port
// results leave via a pending slot and an output register; a match waits while both are full
// reset (rst, synchronous): goal and candidate count cleared, no result pending
module three_sum_search_unit #(
  parameter int MAX_CANDIDATES = tss_pkg::MAX_CANDIDATES
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic signed [tss_pkg::GOAL_W-1:0]     cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [tss_pkg::VAL_W-1:0]      candidate_value,
  input  logic                                  is_last,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  found,
  output logic [tss_pkg::IDX_OUT_W-1:0]         first_index,
  output logic [tss_pkg::IDX_OUT_W-1:0]         second_index,
  output logic [tss_pkg::IDX_OUT_W-1:0]         third_index,
  output logic signed [tss_pkg::VAL_W-1:0]      first_value,
  output logic signed [tss_pkg::VAL_W-1:0]      second_value,
  output logic signed [tss_pkg::VAL_W-1:0]      third_value,
  output logic                                  last_of_run
);

  localparam int VAL_W  = tss_pkg::VAL_W;
  localparam int GOAL_W = tss_pkg::GOAL_W;
  localparam int OIW    = tss_pkg::IDX_OUT_W;
  localparam int IDX_W  = $clog2(MAX_CANDIDATES);
  localparam int CNT_W  = $clog2(MAX_CANDIDATES + 1);
  localparam int CW1    = CNT_W + 1;
  localparam int PAIR_W = VAL_W + 1;

  tss_pkg::state_t state, state_next;

  logic signed [GOAL_W-1:0] goal;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         i, j, k;
  logic [VAL_W-1:0]         val_i;
  logic [PAIR_W-1:0]        pair_sum;

  logic                     pend_valid;
  logic [IDX_W-1:0]         pend_i, pend_j, pend_k;
  logic [VAL_W-1:0]         pend_vi, pend_vj, pend_vk;

  logic                     in_xfer;
  logic                     wr_en;
  logic [IDX_W-1:0]         rd_addr;
  logic [VAL_W-1:0]         rd_data;
  logic [GOAL_W-1:0]        sum_k;
  logic                     match;
  logic                     out_free;
  logic                     step_ok;
  logic                     emit_mid;
  logic                     emit_end;
  logic                     k_more, j_more, i_more, start_more;
  logic [CNT_W-1:0]         count_inc;

  tss_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_CANDIDATES)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[IDX_W-1:0]),
    .wr_data (candidate_value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign sum_k     = {pair_sum[PAIR_W-1], pair_sum} + {{2{rd_data[VAL_W-1]}}, rd_data};
  assign match     = (sum_k == goal);
  assign step_ok   = !(match && pend_valid) || out_free;
  assign count_inc = (count < CNT_W'(MAX_CANDIDATES)) ? count + CNT_W'(1) : count;

  assign k_more     = (CW1'(k) + CW1'(1)) < CW1'(count);
  assign j_more     = (CW1'(j) + CW1'(2)) < CW1'(count);
  assign i_more     = (CW1'(i) + CW1'(3)) < CW1'(count);
  assign start_more = CW1'(count_inc) >= CW1'(3);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tss_pkg::S_IDLE: begin
        if (in_xfer && is_last) begin
          state_next = start_more ? tss_pkg::S_FETCH_I : tss_pkg::S_FINISH;
        end
      end
      tss_pkg::S_FETCH_I: state_next = tss_pkg::S_LOAD_I;
      tss_pkg::S_LOAD_I:  state_next = tss_pkg::S_FETCH_J;
      tss_pkg::S_FETCH_J: state_next = tss_pkg::S_LOAD_J;
      tss_pkg::S_LOAD_J:  state_next = tss_pkg::S_FETCH_K;
      tss_pkg::S_FETCH_K: state_next = tss_pkg::S_CHECK;
      tss_pkg::S_CHECK: begin
        if (step_ok) begin
          if (k_more) begin
            state_next = tss_pkg::S_FETCH_K;
          end else if (j_more) begin
            state_next = tss_pkg::S_FETCH_J;
          end else if (i_more) begin
            state_next = tss_pkg::S_FETCH_I;
          end else begin
            state_next = tss_pkg::S_FINISH;
          end
        end
      end
      tss_pkg::S_FINISH: begin
        if (out_free) begin
          state_next = tss_pkg::S_IDLE;
        end
      end
      default: state_next = tss_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall = 1'b1;
    wr_en    = 1'b0;
    rd_addr  = k[IDX_W-1:0];
    emit_mid = 1'b0;
    emit_end = 1'b0;
    case (state)
      tss_pkg::S_IDLE: begin
        in_stall = 1'b0;
        wr_en    = in_valid && (count < CNT_W'(MAX_CANDIDATES));
      end
      tss_pkg::S_FETCH_I: rd_addr = i[IDX_W-1:0];
      tss_pkg::S_FETCH_J: rd_addr = j[IDX_W-1:0];
      tss_pkg::S_CHECK:   emit_mid = match && pend_valid && out_free;
      tss_pkg::S_FINISH:  emit_end = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tss_pkg::S_IDLE;
      goal       <= '0;
      count      <= '0;
      pend_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        goal <= cfg_data;
      end
      if (in_xfer) begin
        count <= count_inc;
      end
      if (state == tss_pkg::S_CHECK && step_ok && match) begin
        pend_valid <= 1'b1;
      end
      if (emit_end) begin
        pend_valid <= 1'b0;
        count      <= '0;
      end
    end
  end

  // search counters and operands
  always_ff @(posedge clk) begin
    case (state)
      tss_pkg::S_IDLE: i <= '0;
      tss_pkg::S_LOAD_I: begin
        val_i <= rd_data;
        j     <= i + CNT_W'(1);
      end
      tss_pkg::S_LOAD_J: begin
        pair_sum <= {val_i[VAL_W-1], val_i} + {rd_data[VAL_W-1], rd_data};
        k        <= j + CNT_W'(1);
      end
      tss_pkg::S_CHECK: begin
        if (step_ok) begin
          if (match) begin
            pend_i  <= i[IDX_W-1:0];
            pend_j  <= j[IDX_W-1:0];
            pend_k  <= k[IDX_W-1:0];
            pend_vi <= val_i;
            pend_vj <= pair_sum[VAL_W-1:0] - val_i;
            pend_vk <= rd_data;
          end
          if (k_more) begin
            k <= k + CNT_W'(1);
          end else if (j_more) begin
            j <= j + CNT_W'(1);
          end else if (i_more) begin
            i <= i + CNT_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_mid || emit_end) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_mid || (emit_end && pend_valid)) begin
      found        <= 1'b1;
      first_index  <= OIW'(pend_i);
      second_index <= OIW'(pend_j);
      third_index  <= OIW'(pend_k);
      first_value  <= pend_vi;
      second_value <= pend_vj;
      third_value  <= pend_vk;
      last_of_run  <= emit_end;
    end else if (emit_end) begin
      found        <= 1'b0;
      first_index  <= '0;
      second_index <= '0;
      third_index  <= '0;
      first_value  <= '0;
      second_value <= '0;
      third_value  <= '0;
      last_of_run  <= 1'b1;
    end
  end

endmodule

// File: src/tss_ram.sv
module tss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
